@@ hdl/lte_pkg.sv @@
// Shared types and constants of the LED twinkle and fade engine.
package lte_pkg;

  localparam int MAX_LEDS = 1024;
  localparam int IDX_W    = $clog2(MAX_LEDS);
  localparam int CNT_W    = 11;
  localparam int LEVEL_W  = 16;
  localparam int ACC_W    = 25;
  localparam int RAND_W   = 32;
  localparam int CFG_W    = 32;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 16'h8000;
  localparam logic [RAND_W-1:0]  LFSR_TAPS  = 32'hD000_0001;
  localparam logic [ACC_W-1:0]   ACC_ONE    = 25'h001_0000;

  localparam logic [23:0]       SPARK_RESET = 24'hFF_FFFF;
  localparam logic [23:0]       BASE_RESET  = 24'h00_0020;
  localparam logic [23:0]       INC_RESET   = 24'd12976;
  localparam logic [15:0]       DECAY_RESET = 16'd63408;
  localparam logic [CNT_W-1:0]  COUNT_RESET = 11'd1024;
  localparam logic [RAND_W-1:0] SEED_RESET  = 32'd1;

  typedef enum logic [2:0] {
    CFG_SPARK = 3'd0,
    CFG_BASE  = 3'd1,
    CFG_INC   = 3'd2,
    CFG_DECAY = 3'd3,
    CFG_COUNT = 3'd4,
    CFG_SEED  = 3'd5
  } cfg_idx_t;

  localparam logic FUNC_FRAME = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  typedef struct packed {
    logic       func;
    logic [9:0] pixel_index;
  } in_item_t;

  typedef struct packed {
    logic [9:0] out_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

endpackage

@@ hdl/led_twinkle_fade_engine.sv @@
// Top level of the LED twinkle and fade engine: sequencer, shared units and result register.
//
// After reset the block sweeps the brightness memory to zero, one LED per cycle, over all
// MAX_LEDS (1024) entries, and accepts no transaction meanwhile; configuration writes
// are taken at any time. A pixel transaction occupies the block for one memory read,
// one decay multiply, and a multiply and an add for each of the three color channels
// on one shared 17 by 17 signed multiplier, then the result is moved into the output
// register once that register is free. A frame-start transaction spawns its sparks one
// by one; each spark index is the LFSR value reduced modulo the LED count by a restoring
// remainder unit that retires one dividend bit per cycle. The next transaction is
// accepted while a result still waits in the output register.
module led_twinkle_fade_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lte_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lte_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int CMP_W = lte_pkg::CNT_W + 1;
  localparam int BIT_W = $clog2(lte_pkg::RAND_W);

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b0_0000_0001,
    S_IDLE  = 9'b0_0000_0010,
    S_SPAWN = 9'b0_0000_0100,
    S_MOD   = 9'b0_0000_1000,
    S_RD    = 9'b0_0001_0000,
    S_DECAY = 9'b0_0010_0000,
    S_MUL   = 9'b0_0100_0000,
    S_ACC   = 9'b0_1000_0000,
    S_EMIT  = 9'b1_0000_0000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [23:0]                     spark_r, spark_nxt;
  logic [23:0]                     base_r, base_nxt;
  logic [23:0]                     inc_r, inc_nxt;
  logic [15:0]                     decay_r, decay_nxt;
  logic [lte_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [lte_pkg::ACC_W-1:0]       acc_r, acc_nxt;
  logic [lte_pkg::RAND_W-1:0]      lfsr_r, lfsr_nxt;
  logic [lte_pkg::IDX_W-1:0]       clr_r, clr_nxt;
  logic [lte_pkg::RAND_W-1:0]      div_r, div_nxt;
  logic [lte_pkg::IDX_W-1:0]       rem_r, rem_nxt;
  logic [BIT_W-1:0]                bit_r, bit_nxt;
  logic [9:0]                      pix_r, pix_nxt;
  logic [lte_pkg::LEVEL_W-1:0]     level_r, level_nxt;
  logic signed [33:0]              prod_r, prod_nxt;
  logic [1:0]                      ch_r, ch_nxt;
  lte_pkg::out_item_t              res_r, res_nxt;
  logic                            out_valid_r, out_valid_nxt;
  lte_pkg::out_item_t              out_data_r, out_data_nxt;

  logic                            ram_we;
  logic [lte_pkg::IDX_W-1:0]       ram_waddr;
  logic [lte_pkg::LEVEL_W-1:0]     ram_wdata;
  logic [lte_pkg::IDX_W-1:0]       ram_raddr;
  logic [lte_pkg::LEVEL_W-1:0]     ram_rdata;

  logic [lte_pkg::CNT_W-1:0]       n_eff;
  logic [lte_pkg::RAND_W-1:0]      lfsr_step;
  logic [lte_pkg::RAND_W-1:0]      seed_val;
  logic [lte_pkg::IDX_W:0]         rem_shift;
  logic [CMP_W-1:0]                rem_diff;
  logic [lte_pkg::IDX_W-1:0]       rem_new;
  logic [lte_pkg::LEVEL_W-1:0]     level_clamp;
  logic [7:0]                      spark_ch, base_ch;
  logic signed [8:0]               color_diff;
  logic signed [16:0]              mul_a, mul_b;
  logic signed [33:0]              mul_p;
  logic signed [33:0]              blend_v;
  logic [7:0]                      blend_ch;
  logic                            in_fire;

  lte_ram #(
    .WIDTH(lte_pkg::LEVEL_W),
    .DEPTH(lte_pkg::MAX_LEDS)
  ) u_level_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (count_r == '0) begin
      n_eff = lte_pkg::CNT_W'(1);
    end else if (int'(count_r) > lte_pkg::MAX_LEDS) begin
      n_eff = lte_pkg::CNT_W'(lte_pkg::MAX_LEDS);
    end else begin
      n_eff = count_r;
    end
  end

  assign lfsr_step = lfsr_r[0] ? ((lfsr_r >> 1) ^ lte_pkg::LFSR_TAPS) : (lfsr_r >> 1);
  assign seed_val  = (cfg_wdata == '0) ? lte_pkg::RAND_W'(1) : cfg_wdata;

  assign rem_shift = {rem_r, div_r[lte_pkg::RAND_W-1]};
  assign rem_diff  = CMP_W'(rem_shift) - CMP_W'(n_eff);
  assign rem_new   = (CMP_W'(rem_shift) >= CMP_W'(n_eff)) ? rem_diff[lte_pkg::IDX_W-1:0]
                                                          : rem_shift[lte_pkg::IDX_W-1:0];

  assign level_clamp = (ram_rdata > lte_pkg::LEVEL_FULL) ? lte_pkg::LEVEL_FULL : ram_rdata;

  always_comb begin
    case (ch_r)
      CH_RED: begin
        spark_ch = spark_r[23:16];
        base_ch  = base_r[23:16];
      end
      CH_GREEN: begin
        spark_ch = spark_r[15:8];
        base_ch  = base_r[15:8];
      end
      default: begin
        spark_ch = spark_r[7:0];
        base_ch  = base_r[7:0];
      end
    endcase
  end

  assign color_diff = $signed({1'b0, spark_ch}) - $signed({1'b0, base_ch});

  always_comb begin
    if (state_r == S_RD) begin
      mul_a = $signed({1'b0, level_clamp});
      mul_b = $signed({1'b0, decay_r});
    end else begin
      mul_a = $signed({1'b0, level_r});
      mul_b = 17'(color_diff);
    end
  end

  assign mul_p    = mul_a * mul_b;
  assign blend_v  = $signed({11'b0, base_ch, 15'b0}) + prod_r;
  assign blend_ch = blend_v[33] ? 8'd0 : blend_v[22:15];

  always_comb begin
    state_nxt     = state_r;
    spark_nxt     = spark_r;
    base_nxt      = base_r;
    inc_nxt       = inc_r;
    decay_nxt     = decay_r;
    count_nxt     = count_r;
    acc_nxt       = acc_r;
    lfsr_nxt      = lfsr_r;
    clr_nxt       = clr_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    pix_nxt       = pix_r;
    level_nxt     = level_r;
    prod_nxt      = prod_r;
    ch_nxt        = ch_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_waddr     = clr_r;
    ram_wdata     = '0;
    ram_raddr     = in_data.pixel_index[lte_pkg::IDX_W-1:0];

    unique case (state_r)
      S_CLEAR: begin
        ram_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (int'(clr_r) == lte_pkg::MAX_LEDS - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          pix_nxt = in_data.pixel_index;
          if (in_data.func == lte_pkg::FUNC_FRAME) begin
            acc_nxt   = acc_r + lte_pkg::ACC_W'(inc_r);
            state_nxt = S_SPAWN;
          end else if (int'(in_data.pixel_index) < lte_pkg::MAX_LEDS) begin
            state_nxt = S_RD;
          end
        end
      end
      S_SPAWN: begin
        if (acc_r >= lte_pkg::ACC_ONE) begin
          acc_nxt   = acc_r - lte_pkg::ACC_ONE;
          lfsr_nxt  = lfsr_step;
          div_nxt   = lfsr_step;
          rem_nxt   = '0;
          bit_nxt   = BIT_W'(lte_pkg::RAND_W - 1);
          state_nxt = S_MOD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MOD: begin
        rem_nxt = rem_new;
        div_nxt = div_r << 1;
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) begin
          ram_we    = 1'b1;
          ram_waddr = rem_new;
          ram_wdata = lte_pkg::LEVEL_FULL;
          state_nxt = S_SPAWN;
        end
      end
      S_RD: begin
        prod_nxt  = mul_p;
        state_nxt = S_DECAY;
      end
      S_DECAY: begin
        level_nxt = prod_r[31:16];
        ram_we    = 1'b1;
        ram_waddr = pix_r[lte_pkg::IDX_W-1:0];
        ram_wdata = prod_r[31:16];
        ch_nxt    = CH_RED;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        case (ch_r)
          CH_RED:   res_nxt.red   = blend_ch;
          CH_GREEN: res_nxt.green = blend_ch;
          default:  res_nxt.blue  = blend_ch;
        endcase
        ch_nxt = ch_r + 1'b1;
        if (ch_r == CH_BLUE) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt           = res_r;
          out_data_nxt.out_index = pix_r;
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        lte_pkg::CFG_SPARK: spark_nxt = cfg_wdata[23:0];
        lte_pkg::CFG_BASE:  base_nxt  = cfg_wdata[23:0];
        lte_pkg::CFG_INC:   inc_nxt   = cfg_wdata[23:0];
        lte_pkg::CFG_DECAY: decay_nxt = cfg_wdata[15:0];
        lte_pkg::CFG_COUNT: count_nxt = cfg_wdata[lte_pkg::CNT_W-1:0];
        lte_pkg::CFG_SEED:  lfsr_nxt  = seed_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      spark_r     <= lte_pkg::SPARK_RESET;
      base_r      <= lte_pkg::BASE_RESET;
      inc_r       <= lte_pkg::INC_RESET;
      decay_r     <= lte_pkg::DECAY_RESET;
      count_r     <= lte_pkg::COUNT_RESET;
      acc_r       <= '0;
      lfsr_r      <= lte_pkg::SEED_RESET;
      clr_r       <= '0;
      bit_r       <= '0;
      ch_r        <= CH_RED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      spark_r     <= spark_nxt;
      base_r      <= base_nxt;
      inc_r       <= inc_nxt;
      decay_r     <= decay_nxt;
      count_r     <= count_nxt;
      acc_r       <= acc_nxt;
      lfsr_r      <= lfsr_nxt;
      clr_r       <= clr_nxt;
      bit_r       <= bit_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    pix_r      <= pix_nxt;
    level_r    <= level_nxt;
    prod_r     <= prod_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ hdl/lte_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module lte_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ test/led_twinkle_fade_engine_test.sv @@
// Self-checking testbench for the LED twinkle and fade engine with its own behavioral predictor.
`timescale 1ns / 100ps

module led_twinkle_fade_engine_test;
  import lte_pkg::*;

  typedef struct {
    in_item_t item;
    bit       drain_first;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_SPARK;
  logic [31:0] cfg_wdata = '0;

  led_twinkle_fade_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor state: configuration, per-LED levels, spawn accumulator and LFSR.
  logic [23:0]        spark_rgb;
  logic [23:0]        base_rgb;
  logic [23:0]        spawn_inc;
  logic [15:0]        decay_mul;
  logic [CNT_W-1:0]   led_count_cfg;
  logic [LEVEL_W-1:0] level_mem [MAX_LEDS];
  logic [ACC_W-1:0]   spawn_acc;
  logic [RAND_W-1:0]  lfsr;

  stim_t       pending_items[$];
  out_item_t   pending_colors[$];
  out_item_t   want;
  stim_t       cur;
  int unsigned pushed_count = 0;
  int unsigned accepted_count = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  logic        in_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned long_hold_at = 100;
  int unsigned rx_mode = 0;
  int unsigned mode_left = 0;

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int unsigned effective_leds();
    if (led_count_cfg == 0) return 1;
    if (led_count_cfg > MAX_LEDS) return MAX_LEDS;
    return led_count_cfg;
  endfunction

  function automatic logic [7:0] mix_channel(input logic [7:0] spark, input logic [7:0] base,
                                             input int unsigned level);
    int v;
    v = int'(base) * 32768 + int'(level) * (int'(spark) - int'(base));
    if (v < 0) v = 0;
    return 8'(v >> 15);
  endfunction

  task automatic predictor_reset();
    spark_rgb     = SPARK_RESET;
    base_rgb      = BASE_RESET;
    spawn_inc     = INC_RESET;
    decay_mul     = DECAY_RESET;
    led_count_cfg = COUNT_RESET;
    lfsr          = SEED_RESET;
    spawn_acc     = '0;
    for (int i = 0; i < MAX_LEDS; i++) level_mem[i] = '0;
  endtask

  // Applies one accepted transaction to the predictor and queues the expected color of a pixel.
  task automatic advance_twinkle(input in_item_t it);
    int unsigned n;
    int unsigned lvl;
    out_item_t   c;
    if (it.func == FUNC_FRAME) begin
      n = effective_leds();
      spawn_acc = spawn_acc + spawn_inc;
      while (spawn_acc >= ACC_ONE) begin
        lfsr = (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : '0);
        level_mem[lfsr % n] = LEVEL_FULL;
        spawn_acc = spawn_acc - ACC_ONE;
      end
    end else begin
      lvl = level_mem[it.pixel_index];
      if (lvl > LEVEL_FULL) lvl = LEVEL_FULL;
      lvl = (lvl * decay_mul) >> 16;
      level_mem[it.pixel_index] = LEVEL_W'(lvl);
      c.out_index = it.pixel_index;
      c.red       = mix_channel(spark_rgb[23:16], base_rgb[23:16], lvl);
      c.green     = mix_channel(spark_rgb[15:8], base_rgb[15:8], lvl);
      c.blue      = mix_channel(spark_rgb[7:0], base_rgb[7:0], lvl);
      pending_colors.push_back(c);
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_SPARK: spark_rgb = value[23:0];
      CFG_BASE:  base_rgb = value[23:0];
      CFG_INC:   spawn_inc = value[23:0];
      CFG_DECAY: decay_mul = value[15:0];
      CFG_COUNT: led_count_cfg = value[CNT_W-1:0];
      CFG_SEED:  lfsr = (value == 0) ? 32'd1 : value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_item(input logic func, input int unsigned idx, input bit drain);
    stim_t s;
    s.item.func        = func;
    s.item.pixel_index = idx[9:0];
    s.drain_first      = drain;
    pending_items.push_back(s);
    pushed_count++;
  endtask

  // Pixel indices mostly fall on LEDs that sparks can reach.
  task automatic queue_random_items(input int count, input int frame_pct);
    int unsigned span;
    span = effective_leds();
    repeat (count) begin
      if ($urandom_range(0, 99) < frame_pct)
        push_item(FUNC_FRAME, $urandom_range(0, 1023), $urandom_range(0, 99) == 0);
      else if ($urandom_range(0, 99) < 70)
        push_item(FUNC_PIXEL, $urandom_range(0, span - 1), $urandom_range(0, 99) == 0);
      else
        push_item(FUNC_PIXEL, $urandom_range(0, 1023), $urandom_range(0, 99) == 0);
    end
  endtask

  // Waits for all transactions and colors, then lets a worst-case spark burst finish.
  task automatic wait_idle();
    int unsigned settle;
    do @(negedge clk);
    while (accepted_count != pushed_count || pending_colors.size() != 0);
    settle = 2 + 33 * ((spawn_inc >> 16) + 1) + 16;
    repeat (settle) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() == 0 ||
                   (pending_items[0].drain_first && pending_colors.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        cur = pending_items.pop_front();
        in_data  <= cur.item;
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left == 0 && results_seen >= long_hold_at) begin
      hold_left = 400;
      long_hold_at = long_hold_at + 300;
    end
    if (mode_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_colors.size() == 0) begin
          report_error($sformatf("unexpected result for LED %0d", out_data.out_index));
        end else begin
          want = pending_colors.pop_front();
          if (out_data.out_index !== want.out_index)
            report_error($sformatf("index: expected %0d, got %0d", want.out_index,
                                   out_data.out_index));
          if (out_data.red !== want.red)
            report_error($sformatf("red of LED %0d: expected %0d, got %0d", want.out_index,
                                   want.red, out_data.red));
          if (out_data.green !== want.green)
            report_error($sformatf("green of LED %0d: expected %0d, got %0d", want.out_index,
                                   want.green, out_data.green));
          if (out_data.blue !== want.blue)
            report_error($sformatf("blue of LED %0d: expected %0d, got %0d", want.out_index,
                                   want.blue, out_data.blue));
        end
      end
      if (in_valid && in_ready) begin
        accepted_count++;
        advance_twinkle(in_data);
      end
    end
    in_taken <= rst_n && in_valid && in_ready;
  end

  initial begin
    predictor_reset();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: every level is zero, so the background color comes out.
    push_item(FUNC_PIXEL, 0, 0);
    push_item(FUNC_PIXEL, 1023, 0);
    wait_idle();

    // A zero LED count acts as one and a zero seed loads as one, so every spark hits LED 0.
    write_reg(CFG_COUNT, 0);
    write_reg(CFG_INC, 32'h0001_0000);
    write_reg(CFG_SEED, 0);
    push_item(FUNC_FRAME, 0, 0);
    push_item(FUNC_PIXEL, 0, 0);
    push_item(FUNC_PIXEL, 0, 0);
    push_item(FUNC_PIXEL, 1, 0);
    push_item(FUNC_FRAME, 1023, 0);
    push_item(FUNC_FRAME, 0, 0);
    push_item(FUNC_PIXEL, 0, 1);
    wait_idle();

    // Oversized LED count, largest increment and decay, inverted color extremes.
    write_reg(CFG_COUNT, 2047);
    write_reg(CFG_INC, 32'h00FF_FFFF);
    write_reg(CFG_DECAY, 32'h0000_FFFF);
    write_reg(CFG_SPARK, 32'h0000_0000);
    write_reg(CFG_BASE, 32'h00FF_FFFF);
    write_reg(CFG_SEED, 32'hFFFF_FFFF);
    push_item(FUNC_FRAME, 0, 0);
    push_item(FUNC_PIXEL, 0, 0);
    push_item(FUNC_PIXEL, 1023, 0);
    push_item(FUNC_PIXEL, 512, 0);
    push_item(FUNC_PIXEL, 10'h2AA, 0);
    push_item(FUNC_PIXEL, 10'h155, 0);
    push_item(FUNC_FRAME, 1023, 0);
    push_item(FUNC_PIXEL, 1023, 0);
    wait_idle();

    // Zero decay and zero increment.
    write_reg(CFG_DECAY, 0);
    write_reg(CFG_INC, 0);
    write_reg(CFG_SPARK, 32'h00FF_FFFF);
    write_reg(CFG_BASE, 32'h0000_0000);
    push_item(FUNC_PIXEL, 1023, 0);
    push_item(FUNC_PIXEL, 0, 0);
    push_item(FUNC_FRAME, 0, 0);
    push_item(FUNC_PIXEL, 512, 0);
    wait_idle();

    write_reg(CFG_COUNT, 8);
    write_reg(CFG_INC, 32'h0000_8000);
    write_reg(CFG_DECAY, 32'h0000_F000);
    write_reg(CFG_SPARK, $urandom_range(0, 24'hFF_FFFF));
    write_reg(CFG_BASE, $urandom_range(0, 24'hFF_FFFF));
    write_reg(CFG_SEED, $urandom);
    queue_random_items(150, 15);
    wait_idle();

    write_reg(CFG_COUNT, 1);
    write_reg(CFG_INC, 32'h0002_0000);
    write_reg(CFG_DECAY, 32'h0000_FFFF);
    write_reg(CFG_SPARK, 32'h00FF_FFFF);
    write_reg(CFG_BASE, 32'h0000_0000);
    queue_random_items(100, 10);
    wait_idle();

    write_reg(CFG_COUNT, 1024);
    write_reg(CFG_INC, 32'h0000_1000);
    write_reg(CFG_DECAY, $urandom_range(0, 16'hFFFF));
    write_reg(CFG_SPARK, $urandom_range(0, 24'hFF_FFFF));
    queue_random_items(110, 20);
    wait_idle();

    write_reg(CFG_COUNT, 3);
    write_reg(CFG_INC, 32'h0003_0000);
    write_reg(CFG_DECAY, 32'h0000_E000);
    write_reg(CFG_BASE, $urandom_range(0, 24'hFF_FFFF));
    queue_random_items(140, 15);
    wait_idle();

    write_reg(CFG_COUNT, 1500);
    write_reg(CFG_SEED, $urandom);
    write_reg(CFG_INC, 32'h0001_8000);
    queue_random_items(110, 15);
    wait_idle();

    write_reg(CFG_COUNT, 2047);
    write_reg(CFG_INC, 32'h00FF_FFFF);
    write_reg(CFG_DECAY, 32'h0000_FFFF);
    queue_random_items(80, 4);
    wait_idle();

    // Raw random words, upper bits included, on every register.
    write_reg(CFG_SPARK, $urandom);
    write_reg(CFG_BASE, $urandom);
    write_reg(CFG_INC, $urandom);
    write_reg(CFG_DECAY, $urandom);
    write_reg(CFG_COUNT, $urandom);
    write_reg(CFG_SEED, $urandom);
    queue_random_items(120, 6);
    wait_idle();

    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
